// ----- rtl/dsdp_pkg.sv -----
`timescale 1ns / 1ps

package dsdp_pkg;

  localparam int SUM_WIDTH_DEF = 40;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_BAND    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_BAND    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MM_PER_COUNT = 3'd5;

  localparam logic [15:0] STOP_BAND_RST    = 16'd256;
  localparam logic [15:0] SLOW_BAND_RST    = 16'd0;
  localparam logic [15:0] MM_PER_COUNT_RST = 16'd1024;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  localparam int POS_W  = 24;
  localparam int ERR_W  = 25;
  localparam int DRV_W  = 16;
  localparam int MUL_AW = 17;
  localparam int MUL_BW = 26;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int ACC_W  = 64;
  localparam int SCL_W  = 49;
  localparam int LO_W   = 24;

  localparam logic signed [ERR_W-1:0] ERR_MAX = 25'sh0FF_FFFF;
  localparam logic signed [ERR_W-1:0] ERR_MIN = 25'sh100_0000;

  localparam logic signed [ACC_W-1:0] SUM_CLAMP = 64'sh0000_8000_0000_0000;

  localparam logic signed [DRV_W-1:0] DRV_MAX = 16'sh7FFF;
  localparam logic signed [DRV_W-1:0] DRV_MIN = 16'sh8000;

endpackage

// ----- rtl/dual_side_distance_pid.sv -----
`timescale 1ns / 1ps

// channel  dir  handshake               payload
// in_      in   in_tvalid / in_tready   in_tdata (72b), in_tuser (action)
// out_     out  out_tvalid / out_tready out_tdata (40b)
// cfg_     in   cfg_wen                 cfg_index (3b), cfg_wdata (16b)
//
// Start beat: to ST_OUT. Tick beat: ST_POS per side, then for an armed side
// ST_ERR, ST_SUM, ST_MUL_P to ST_FIN on the shared 17x26 multiplier; it
// quits after ST_SUM on stop or slow. One beat at a time; in_tready is low
// from accept until the result is loaded into the output register, which
// holds it against out_tready. Synchronous active-low reset, no clearing pass.

module dual_side_distance_pid #(
  parameter int SUM_WIDTH = dsdp_pkg::SUM_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [23:0] target_distance, [47:24] left_position, [71:48] right_position
  input  logic [71:0]                        in_tdata,
  // [0] action
  input  logic [0:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [15:0] left_drive, [31:16] right_drive, [32] left_armed,
  // [33] right_armed, [34] move_done, [39:35] zero
  output logic [39:0]                        out_tdata,
  input  logic                               cfg_wen,
  input  logic [dsdp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dsdp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int PW = dsdp_pkg::POS_W;
  localparam int EW = dsdp_pkg::ERR_W;
  localparam int DW = dsdp_pkg::DRV_W;
  localparam int AW = dsdp_pkg::MUL_AW;
  localparam int BW = dsdp_pkg::MUL_BW;
  localparam int MW = dsdp_pkg::MUL_PW;
  localparam int CW = dsdp_pkg::ACC_W;
  localparam int SW = dsdp_pkg::SCL_W;
  localparam int LW = dsdp_pkg::LO_W;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_POS    = 11'b000_0000_0010,
    ST_ERR    = 11'b000_0000_0100,
    ST_SUM    = 11'b000_0000_1000,
    ST_MUL_P  = 11'b000_0001_0000,
    ST_MUL_D  = 11'b000_0010_0000,
    ST_MUL_IL = 11'b000_0100_0000,
    ST_MUL_IH = 11'b000_1000_0000,
    ST_ACC    = 11'b001_0000_0000,
    ST_FIN    = 11'b010_0000_0000,
    ST_OUT    = 11'b100_0000_0000
  } state_t;

  state_t state_r;

  logic [15:0] gain_p_r, gain_i_r, gain_d_r, stop_band_r, slow_band_r, mmpc_r;

  logic signed [PW-1:0]        target_r;
  logic signed [PW-1:0]        lpos_r, rpos_r;
  logic signed [SUM_WIDTH-1:0] sum_r   [2];
  logic signed [EW-1:0]        prev_r  [2];
  logic signed [DW-1:0]        power_r [2];
  logic [1:0]                  armed_r;
  logic                        side_r;
  logic signed [EW-1:0]        err_r;
  logic signed [MW-1:0]        prod_r;
  logic signed [CW-1:0]        acc_r;
  logic                        out_valid_r;
  logic [39:0]                 out_data_r;

  logic                        in_acc;
  logic signed [PW-1:0]        cnt;
  logic [PW-1:0]               mag, tgt;
  logic [35:0]                 pos;
  logic signed [37:0]          e_wide;
  logic signed [EW-1:0]        e_sat;
  logic signed [SUM_WIDTH-1:0] sum_cur;
  logic signed [SUM_WIDTH:0]   sum_wide;
  logic signed [SUM_WIDTH-1:0] sum_sat;
  logic signed [SUM_WIDTH-1:0] sum_max, sum_min;
  logic [EW-1:0]               ae;
  logic                        in_stop, in_slow;
  logic signed [DW-1:0]        pw_cur, pw_adj, pw_half;
  logic signed [CW-1:0]        s64;
  logic signed [SW-1:0]        s_cl;
  logic signed [BW-1:0]        dif;
  logic signed [AW-1:0]        mul_a;
  logic signed [BW-1:0]        mul_b;
  logic signed [MW-1:0]        mul_p;
  logic signed [CW-1:0]        addend;
  logic signed [CW-17:0]       q;
  logic signed [DW-1:0]        q_sat;
  logic                        out_free;
  logic [DW-1:0]               ldrv, rdrv;

  function automatic logic [DW-1:0] drv(input logic signed [DW-1:0] p,
                                        input logic armed,
                                        input logic signed [PW-1:0] t);
    logic [DW-1:0] d;
    d = '0;
    if (armed) begin
      if (t > 0) begin
        d = p;
      end else if (t < 0) begin
        d = (p == dsdp_pkg::DRV_MIN) ? dsdp_pkg::DRV_MAX : -p;
      end
    end
    return d;
  endfunction

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign cnt = side_r ? rpos_r : lpos_r;
  assign mag = cnt[PW-1] ? PW'(-cnt) : PW'(cnt);
  assign tgt = target_r[PW-1] ? PW'(-target_r) : PW'(target_r);
  assign pos = prod_r[39:4];
  assign e_wide = $signed({14'b0, tgt}) - $signed({2'b0, pos});

  always_comb begin
    if (e_wide > 38'(dsdp_pkg::ERR_MAX)) begin
      e_sat = dsdp_pkg::ERR_MAX;
    end else if (e_wide < 38'(dsdp_pkg::ERR_MIN)) begin
      e_sat = dsdp_pkg::ERR_MIN;
    end else begin
      e_sat = EW'(e_wide);
    end
  end

  assign sum_cur  = sum_r[side_r];
  assign sum_max  = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  assign sum_min  = {1'b1, {(SUM_WIDTH-1){1'b0}}};
  assign sum_wide = (SUM_WIDTH+1)'(sum_cur) + (SUM_WIDTH+1)'(err_r);

  always_comb begin
    if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
      sum_sat = sum_wide[SUM_WIDTH] ? sum_min : sum_max;
    end else begin
      sum_sat = SUM_WIDTH'(sum_wide);
    end
  end

  assign ae      = err_r[EW-1] ? EW'(-err_r) : EW'(err_r);
  assign in_stop = ae <= {9'b0, stop_band_r};
  assign in_slow = ae < {9'b0, slow_band_r};
  assign pw_cur  = power_r[side_r];
  assign pw_adj  = pw_cur + $signed({{(DW-1){1'b0}}, pw_cur[DW-1]});
  assign pw_half = pw_adj >>> 1;

  assign s64 = CW'(sum_cur);

  always_comb begin
    if (s64 > dsdp_pkg::SUM_CLAMP) begin
      s_cl = SW'(dsdp_pkg::SUM_CLAMP);
    end else if (s64 < -dsdp_pkg::SUM_CLAMP) begin
      s_cl = SW'(-dsdp_pkg::SUM_CLAMP);
    end else begin
      s_cl = SW'(s64);
    end
  end

  assign dif = BW'(prev_r[side_r]) - BW'(err_r);

  always_comb begin
    case (state_r)
      ST_POS: begin
        mul_a = $signed({1'b0, mmpc_r});
        mul_b = $signed({2'b0, mag});
      end
      ST_MUL_P: begin
        mul_a = AW'($signed(gain_p_r));
        mul_b = BW'(err_r);
      end
      ST_MUL_D: begin
        mul_a = AW'($signed(gain_d_r));
        mul_b = dif;
      end
      ST_MUL_IL: begin
        mul_a = AW'($signed(gain_i_r));
        mul_b = $signed({2'b0, s_cl[LW-1:0]});
      end
      ST_MUL_IH: begin
        mul_a = AW'($signed(gain_i_r));
        mul_b = BW'($signed(s_cl[SW-1:LW]));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p  = mul_a * mul_b;
  assign addend = (state_r == ST_ACC) ? (CW'(prod_r) <<< LW) : CW'(prod_r);
  assign q      = acc_r[CW-1:16];

  always_comb begin
    if (q > (CW-16)'(dsdp_pkg::DRV_MAX)) begin
      q_sat = dsdp_pkg::DRV_MAX;
    end else if (q < (CW-16)'(dsdp_pkg::DRV_MIN)) begin
      q_sat = dsdp_pkg::DRV_MIN;
    end else begin
      q_sat = DW'(q);
    end
  end

  assign ldrv = drv(power_r[0], armed_r[0], target_r);
  assign rdrv = drv(power_r[1], armed_r[1], target_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r    <= '0;
      gain_i_r    <= '0;
      gain_d_r    <= '0;
      stop_band_r <= dsdp_pkg::STOP_BAND_RST;
      slow_band_r <= dsdp_pkg::SLOW_BAND_RST;
      mmpc_r      <= dsdp_pkg::MM_PER_COUNT_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        dsdp_pkg::REG_GAIN_P:       gain_p_r    <= cfg_wdata;
        dsdp_pkg::REG_GAIN_I:       gain_i_r    <= cfg_wdata;
        dsdp_pkg::REG_GAIN_D:       gain_d_r    <= cfg_wdata;
        dsdp_pkg::REG_STOP_BAND:    stop_band_r <= cfg_wdata;
        dsdp_pkg::REG_SLOW_BAND:    slow_band_r <= cfg_wdata;
        dsdp_pkg::REG_MM_PER_COUNT: mmpc_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      target_r    <= '0;
      sum_r[0]    <= '0;
      sum_r[1]    <= '0;
      prev_r[0]   <= '0;
      prev_r[1]   <= '0;
      power_r[0]  <= '0;
      power_r[1]  <= '0;
      armed_r     <= '0;
      side_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      prod_r <= mul_p;
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_tuser[0] == dsdp_pkg::ACT_START) begin
              target_r   <= in_tdata[23:0];
              sum_r[0]   <= '0;
              sum_r[1]   <= '0;
              prev_r[0]  <= '0;
              prev_r[1]  <= '0;
              power_r[0] <= '0;
              power_r[1] <= '0;
              armed_r    <= {2{in_tdata[23:0] != '0}};
              state_r    <= ST_OUT;
            end else begin
              lpos_r  <= in_tdata[47:24];
              rpos_r  <= in_tdata[71:48];
              side_r  <= 1'b0;
              state_r <= ST_POS;
            end
          end
        end
        ST_POS: begin
          if (armed_r[side_r]) begin
            state_r <= ST_ERR;
          end else if (!side_r) begin
            side_r <= 1'b1;
          end else begin
            state_r <= ST_OUT;
          end
        end
        ST_ERR: begin
          err_r   <= e_sat;
          state_r <= ST_SUM;
        end
        ST_SUM: begin
          sum_r[side_r] <= sum_sat;
          if (in_stop || in_slow) begin
            if (in_stop) begin
              power_r[side_r] <= '0;
              armed_r[side_r] <= 1'b0;
            end else begin
              power_r[side_r] <= pw_half;
            end
            prev_r[side_r] <= err_r;
            if (!side_r) begin
              side_r  <= 1'b1;
              state_r <= ST_POS;
            end else begin
              state_r <= ST_OUT;
            end
          end else begin
            state_r <= ST_MUL_P;
          end
        end
        ST_MUL_P: begin
          state_r <= ST_MUL_D;
        end
        ST_MUL_D: begin
          acc_r   <= addend;
          state_r <= ST_MUL_IL;
        end
        ST_MUL_IL: begin
          acc_r   <= acc_r + addend;
          state_r <= ST_MUL_IH;
        end
        ST_MUL_IH: begin
          acc_r   <= acc_r + addend;
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          acc_r   <= acc_r + addend;
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          power_r[side_r] <= q_sat;
          prev_r[side_r]  <= err_r;
          if (!side_r) begin
            side_r  <= 1'b1;
            state_r <= ST_POS;
          end else begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {5'b0, !armed_r[0] && !armed_r[1], armed_r[1], armed_r[0],
                            rdrv, ldrv};
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
